// File: rtl/core/integer_field_scanner_macros.svh
// Assertion macros shared by the integer field scanner RTL.
`ifndef INTEGER_FIELD_SCANNER_MACROS_SVH
`define INTEGER_FIELD_SCANNER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IFS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define IFS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ifs_pkg.sv
// Types and constants of the integer field scanner.
`timescale 1ns / 1ps

package ifs_pkg;

    localparam int MAX_FIELD_DEF = 512;

    localparam int KIND_W  = 3;
    localparam int WIDTH_W = 10;
    localparam int SIZE_W  = 2;
    localparam int CFG_W   = 10;
    localparam int IDX_W   = 2;
    localparam int LEN_W   = 10;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_CONV_KIND   = 2'd0;
    localparam logic [IDX_W-1:0] REG_FIELD_WIDTH = 2'd1;
    localparam logic [IDX_W-1:0] REG_DEST_SIZE   = 2'd2;

    // Conversion kinds
    localparam logic [KIND_W-1:0] KIND_D = 3'd0;
    localparam logic [KIND_W-1:0] KIND_I = 3'd1;
    localparam logic [KIND_W-1:0] KIND_U = 3'd2;
    localparam logic [KIND_W-1:0] KIND_O = 3'd3;
    localparam logic [KIND_W-1:0] KIND_X = 3'd4;
    localparam logic [KIND_W-1:0] KIND_B = 3'd5;

    // Destination sizes
    localparam logic [SIZE_W-1:0] SIZE_8  = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_16 = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_32 = 2'd2;
    localparam logic [SIZE_W-1:0] SIZE_64 = 2'd3;

    localparam logic [KIND_W-1:0]  KIND_RST  = KIND_D;
    localparam logic [WIDTH_W-1:0] WIDTH_RST = 10'd512;
    localparam logic [SIZE_W-1:0]  SIZE_RST  = SIZE_32;

    // Characters
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    typedef enum logic [1:0] {
        PH_SKIP       = 2'd0,
        PH_AFTER_SIGN = 2'd1,
        PH_ZERO       = 2'd2,
        PH_DIGITS     = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        NB_2  = 2'd0,
        NB_8  = 2'd1,
        NB_10 = 2'd2,
        NB_16 = 2'd3
    } base_t;

endpackage

// File: rtl/core/integer_field_scanner.sv
// Integer field scanner top level: scanf-style integer fields, one after another, from a request stream.
`timescale 1ns / 1ps

// Channel   Handshake           Payload
// --------  ------------------  --------------------------------------------------
// s_        s_valid / s_ready   s_ch, s_end_of_input
// m_        m_valid / m_ready   m_consumed, m_field_done, m_field_ok, m_overflow,
//                               m_value, m_field_length
// cfg_      cfg_wr_en           cfg_index, cfg_data (write only)
//
// One request per cycle sustained while m_ready drains the result register; each
// request lands in the input register; its result goes to the result register when
// that slot is free. The field state update (multiply by base and add) sets the rate.
// aresetn is synchronous, active low; it clears field state and loads register defaults.
// A held result stalls the input register, which in turn drops s_ready.

`include "integer_field_scanner_macros.svh"

module integer_field_scanner
    import ifs_pkg::*;
#(
    parameter int MAX_FIELD = MAX_FIELD_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_wr_en,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_ch,
    input  logic               s_end_of_input,

    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_consumed,
    output logic               m_field_done,
    output logic               m_field_ok,
    output logic               m_overflow,
    output logic [63:0]        m_value,
    output logic [LEN_W-1:0]   m_field_length
);

    // Width counter must hold MAX_FIELD itself.
    localparam int WL = $clog2(MAX_FIELD + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [KIND_W-1:0]  conv_kind_reg;
    logic [WIDTH_W-1:0] field_width_reg;
    logic [SIZE_W-1:0]  dest_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conv_kind_reg   <= KIND_RST;
            field_width_reg <= WIDTH_RST;
            dest_size_reg   <= SIZE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CONV_KIND:   conv_kind_reg   <= cfg_data[KIND_W-1:0];
                REG_FIELD_WIDTH: field_width_reg <= cfg_data[WIDTH_W-1:0];
                REG_DEST_SIZE:   dest_size_reg   <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register: hold one request until the result register frees up
    // ------------------------------------------------------------------
    logic       in_valid_reg;
    logic [7:0] ch_reg;
    logic       eoi_reg;
    logic       out_valid_reg;
    logic       advance;

    // Advance whenever a request is held and the result slot is empty or draining.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ch_reg  <= s_ch;
            eoi_reg <= s_end_of_input;
        end
    end

    // ------------------------------------------------------------------
    // Field state
    // ------------------------------------------------------------------
    phase_t          phase_reg,        phase_next;
    base_t           base_reg,         base_next;
    logic [WL-1:0]   width_left_reg,   width_left_next;
    logic [63:0]     magnitude_reg,    magnitude_next;
    logic            mag_ovf_reg,      mag_ovf_next;
    logic            negative_reg,     negative_next;
    logic            digit_seen_reg,   digit_seen_next;
    logic [LEN_W-1:0] taken_count_reg, taken_count_next;

    // ------------------------------------------------------------------
    // Character classification
    // ------------------------------------------------------------------
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] d;
        d = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) d = 5'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) d = 5'(c - 8'h61 + 8'd10);
        else if (c >= 8'h41 && c <= 8'h46) d = 5'(c - 8'h41 + 8'd10);
        return d;
    endfunction

    function automatic logic [4:0] base_val(input base_t b);
        logic [4:0] v;
        case (b)
            NB_2:    v = 5'd2;
            NB_8:    v = 5'd8;
            NB_10:   v = 5'd10;
            default: v = 5'd16;
        endcase
        return v;
    endfunction

    // magnitude * base + digit, with the carry bits kept for the overflow check
    function automatic logic [67:0] mul_add(input logic [63:0] m, input base_t b,
                                            input logic [4:0] d);
        logic [67:0] p;
        case (b)
            NB_2:    p = {3'b0, m, 1'b0};
            NB_8:    p = {1'b0, m, 3'b0};
            NB_10:   p = {1'b0, m, 3'b0} + {3'b0, m, 1'b0};
            default: p = {m, 4'b0};
        endcase
        return p + 68'(d);
    endfunction

    logic [4:0] digit;
    logic       is_space;
    logic       is_sign;
    logic       is_x;
    logic       kind_is_i;
    logic       kind_signed;
    base_t      start_base;
    logic [WL-1:0] width_sat;

    assign digit     = digit_of(ch_reg);
    assign is_space  = (ch_reg == 8'h20) || (ch_reg >= 8'h09 && ch_reg <= 8'h0D);
    assign is_sign   = (ch_reg == CH_PLUS) || (ch_reg == CH_MINUS);
    assign is_x      = (ch_reg == CH_LOW_X) || (ch_reg == CH_UP_X);
    assign kind_is_i = (conv_kind_reg == KIND_I);
    assign kind_signed = (conv_kind_reg == KIND_D) || (conv_kind_reg == KIND_I)
                       || (conv_kind_reg > KIND_B);

    always_comb begin
        case (conv_kind_reg)
            KIND_I, KIND_X: start_base = NB_16;
            KIND_O:         start_base = NB_8;
            KIND_B:         start_base = NB_2;
            default:        start_base = NB_10;
        endcase
    end

    // Clamp the configured width to MAX_FIELD.
    assign width_sat = (32'(field_width_reg) > 32'(MAX_FIELD)) ? WL'(MAX_FIELD)
                                                               : WL'(field_width_reg);

    // ------------------------------------------------------------------
    // Per-character step: decide what the character does to the field
    // ------------------------------------------------------------------
    phase_t          ph_v;
    base_t           base_v;
    logic [WL-1:0]   wl_v;
    logic [63:0]     mag_v;
    logic            movf_v;
    logic            neg_v;
    logic            ds_v;
    logic [LEN_W-1:0] tc_v;
    logic            took;
    logic            space_skip;
    logic            end_now;
    logic [67:0]     prod;

    always_comb begin
        logic go;
        go         = 1'b0;
        ph_v       = phase_reg;
        base_v     = base_reg;
        wl_v       = width_left_reg;
        mag_v      = magnitude_reg;
        movf_v     = mag_ovf_reg;
        neg_v      = negative_reg;
        ds_v       = digit_seen_reg;
        tc_v       = taken_count_reg;
        took       = 1'b0;
        space_skip = 1'b0;
        end_now    = 1'b0;
        prod       = mul_add(magnitude_reg, base_reg, digit);

        if (phase_reg == PH_SKIP) begin
            if (eoi_reg) begin
                end_now = 1'b1;
            end else if (is_space) begin
                space_skip = 1'b1;
            end else if (field_width_reg == '0) begin
                // Zero width: the first non-blank character ends an empty field.
                end_now = 1'b1;
            end else begin
                // Latch width and base at field start.
                wl_v   = width_sat;
                base_v = start_base;
                ph_v   = PH_AFTER_SIGN;
                if (is_sign) begin
                    neg_v = (ch_reg == CH_MINUS);
                    took  = 1'b1;
                end else begin
                    go = 1'b1;
                end
            end
        end else if (eoi_reg) begin
            end_now = 1'b1;
        end else begin
            go = 1'b1;
        end

        if (go) begin
            if (ph_v == PH_AFTER_SIGN) begin
                if (ch_reg == CH_ZERO && base_v == NB_16) begin
                    // Leading zero counts as a digit; a prefix may follow.
                    ds_v = 1'b1;
                    ph_v = PH_ZERO;
                    took = 1'b1;
                end else begin
                    if (kind_is_i) base_v = NB_10;
                    ph_v = PH_DIGITS;
                end
            end else if (ph_v == PH_ZERO) begin
                if (is_x) begin
                    ph_v = PH_DIGITS;
                    took = 1'b1;
                end else begin
                    if (kind_is_i) base_v = NB_8;
                    ph_v = PH_DIGITS;
                end
            end

            if (!took) begin
                if (digit < base_val(base_v)) begin
                    prod = mul_add(magnitude_reg, base_v, digit);
                    if (!mag_ovf_reg) begin
                        if (prod[67:64] != 4'd0) movf_v = 1'b1;
                        else                     mag_v  = prod[63:0];
                    end
                    ds_v = 1'b1;
                    took = 1'b1;
                end else begin
                    end_now = 1'b1;
                end
            end
        end

        if (took) begin
            tc_v = taken_count_reg + LEN_W'(1);
            if (wl_v != '0) wl_v = wl_v - WL'(1);
            if (wl_v == '0) end_now = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Next state: clear at field end, hold on skipped blanks
    // ------------------------------------------------------------------
    always_comb begin
        phase_next       = phase_reg;
        base_next        = base_reg;
        width_left_next  = width_left_reg;
        magnitude_next   = magnitude_reg;
        mag_ovf_next     = mag_ovf_reg;
        negative_next    = negative_reg;
        digit_seen_next  = digit_seen_reg;
        taken_count_next = taken_count_reg;
        if (end_now) begin
            phase_next       = PH_SKIP;
            base_next        = NB_2;
            width_left_next  = '0;
            magnitude_next   = '0;
            mag_ovf_next     = 1'b0;
            negative_next    = 1'b0;
            digit_seen_next  = 1'b0;
            taken_count_next = '0;
        end else if (took) begin
            phase_next       = ph_v;
            base_next        = base_v;
            width_left_next  = wl_v;
            magnitude_next   = mag_v;
            mag_ovf_next     = movf_v;
            negative_next    = neg_v;
            digit_seen_next  = ds_v;
            taken_count_next = tc_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_SKIP;
            base_reg        <= NB_2;
            width_left_reg  <= '0;
            magnitude_reg   <= '0;
            mag_ovf_reg     <= 1'b0;
            negative_reg    <= 1'b0;
            digit_seen_reg  <= 1'b0;
            taken_count_reg <= '0;
        end else if (advance) begin
            phase_reg       <= phase_next;
            base_reg        <= base_next;
            width_left_reg  <= width_left_next;
            magnitude_reg   <= magnitude_next;
            mag_ovf_reg     <= mag_ovf_next;
            negative_reg    <= negative_next;
            digit_seen_reg  <= digit_seen_next;
            taken_count_reg <= taken_count_next;
        end
    end

    // ------------------------------------------------------------------
    // Result: saturate, negate and truncate at field end
    // ------------------------------------------------------------------
    logic        ok_comb;
    logic        ovf_comb;
    logic [63:0] sat_val;
    logic [63:0] val_comb;

    always_comb begin
        ovf_comb = 1'b0;
        if (kind_signed) begin
            if (neg_v) begin
                if (movf_v || mag_v > 64'h8000_0000_0000_0000) begin
                    sat_val  = 64'h8000_0000_0000_0000;
                    ovf_comb = 1'b1;
                end else begin
                    sat_val = 64'd0 - mag_v;
                end
            end else if (movf_v || mag_v[63]) begin
                sat_val  = 64'h7FFF_FFFF_FFFF_FFFF;
                ovf_comb = 1'b1;
            end else begin
                sat_val = mag_v;
            end
        end else if (movf_v) begin
            sat_val  = '1;
            ovf_comb = 1'b1;
        end else begin
            sat_val = neg_v ? 64'd0 - mag_v : mag_v;
        end

        case (dest_size_reg)
            SIZE_8:  val_comb = {56'd0, sat_val[7:0]};
            SIZE_16: val_comb = {48'd0, sat_val[15:0]};
            SIZE_32: val_comb = {32'd0, sat_val[31:0]};
            default: val_comb = sat_val;
        endcase

        ok_comb = end_now && ds_v;
        if (!ok_comb) begin
            ovf_comb = 1'b0;
            val_comb = '0;
        end
    end

    logic             consumed_reg;
    logic             done_reg;
    logic             ok_reg;
    logic             ovf_reg;
    logic [63:0]      value_reg;
    logic [LEN_W-1:0] length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            consumed_reg <= took || space_skip;
            done_reg     <= end_now;
            ok_reg       <= ok_comb;
            ovf_reg      <= ovf_comb;
            value_reg    <= val_comb;
            length_reg   <= tc_v;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_consumed     = consumed_reg;
    assign m_field_done   = done_reg;
    assign m_field_ok     = ok_reg;
    assign m_overflow     = ovf_reg;
    assign m_value        = value_reg;
    assign m_field_length = length_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `IFS_ASSERT_NOW(a_open_field_quiet, aclk, aresetn,
        out_valid_reg && !done_reg, !ok_reg && !ovf_reg && value_reg == 64'd0,
        "result fields set before field end")
    `IFS_ASSERT_NOW(a_ovf_needs_ok, aclk, aresetn,
        out_valid_reg && ovf_reg, ok_reg && done_reg,
        "overflow reported without a valid field")
    `IFS_ASSERT_NEXT(a_end_clears, aclk, aresetn,
        advance && end_now, phase_reg == PH_SKIP && taken_count_reg == '0 && !digit_seen_reg,
        "field state not cleared after field end")
    `IFS_ASSERT_NEXT(a_skip_no_length, aclk, aresetn,
        advance && phase_reg == PH_SKIP && space_skip, out_valid_reg && length_reg == '0,
        "blank before field counted in field length")

endmodule
